// ----- rtl/environmental_sensor_compensation_top_assert.svh -----
`ifndef ENVIRONMENTAL_SENSOR_COMPENSATION_TOP_ASSERT_SVH
`define ENVIRONMENTAL_SENSOR_COMPENSATION_TOP_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ESC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/esc_pkg.sv -----
`timescale 1ns / 1ps

package esc_pkg;

  // Pipeline geometry.
  localparam int unsigned NS       = 86;
  localparam int unsigned DIV_BITS = 64;
  localparam int unsigned DIV_ST   = DIV_BITS + 2;
  localparam int unsigned DIV_LO   = 12;
  localparam int unsigned DIV_HI   = DIV_LO + DIV_ST - 1;

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_TEMP  = 3'd0;
  localparam logic [2:0] REG_PLOW  = 3'd1;
  localparam logic [2:0] REG_PMID  = 3'd2;
  localparam logic [2:0] REG_PHIGH = 3'd3;
  localparam logic [2:0] REG_HUMA  = 3'd4;
  localparam logic [2:0] REG_HUMB  = 3'd5;

  // Formula constants.
  localparam logic [63:0] T_FINE_P_OFS = 64'd128000;
  localparam logic [63:0] P_RAW_FULL   = 64'd1048576;
  localparam logic [63:0] P_SCALE      = 64'd3125;
  localparam logic [63:0] P_BIAS47     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] T_FINE_H_OFS = 32'd76800;
  localparam logic [31:0] H_ROUND_F1   = 32'd16384;
  localparam logic [31:0] H_OFS_F2B    = 32'd32768;
  localparam logic [31:0] H_OFS_F2C    = 32'd2097152;
  localparam logic [31:0] H_ROUND_F2   = 32'd8192;
  localparam logic [31:0] HUM_MAX      = 32'd419430400;
  localparam logic [31:0] T_ROUND      = 32'd128;
  localparam logic [31:0] MPA_PER_PA   = 32'd1000;
  // (frac * 390625) / 100000 equals (frac * 125) >> 5 exactly.
  localparam logic [14:0] FRAC_MUL     = 15'd125;

  // Partial products of a 64 x 64 multiply, low 64 bits kept.
  typedef struct packed {
    logic [63:0] ll;
    logic [31:0] cr;
  } pp_t;

  // Temperature and humidity values that ride along with the divider.
  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] v2;
    logic [31:0] sq;
  } side_t;

  function automatic logic [31:0] asr32(input logic [31:0] x, input int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [63:0] asr64(input logic [63:0] x, input int unsigned n);
    return 64'($signed(x) >>> n);
  endfunction

  // Three 32 x 32 products; the cross terms only feed the upper word.
  function automatic pp_t pp_mul(input logic [63:0] a, input logic [63:0] b);
    pp_t p;
    p.ll = a[31:0] * b[31:0];
    p.cr = a[31:0] * b[63:32] + a[63:32] * b[31:0];
    return p;
  endfunction

  function automatic logic [63:0] pp_sum(input pp_t p);
    return p.ll + {p.cr, 32'd0};
  endfunction

endpackage

// ----- rtl/esc_sdiv.sv -----
`timescale 1ns / 1ps

module esc_sdiv (
  input  logic                        clk_i,
  input  logic [esc_pkg::DIV_ST-1:0]  en_i,
  input  logic [63:0]                 num_i,
  input  logic [63:0]                 den_i,
  input  esc_pkg::side_t              side_i,
  output logic [63:0]                 quo_o,
  output logic                        inv_o,
  output esc_pkg::side_t              side_o
);
  import esc_pkg::*;

  logic [63:0] rem_q  [0:DIV_BITS];
  logic [63:0] quo_q  [0:DIV_BITS];
  logic [63:0] md_q   [0:DIV_BITS];
  logic        neg_q  [0:DIV_BITS];
  logic        inv_q  [0:DIV_BITS];
  side_t       side_q [0:DIV_BITS];
  logic [63:0] fix_quo_q;
  logic        fix_inv_q;
  side_t       fix_side_q;

  // Setup: magnitudes, quotient sign and the zero-divisor flag.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= '0;
      quo_q[0]  <= num_i[63] ? 64'd0 - num_i : num_i;
      md_q[0]   <= den_i[63] ? 64'd0 - den_i : den_i;
      neg_q[0]  <= num_i[63] ^ den_i[63];
      inv_q[0]  <= (den_i == 64'd0);
      side_q[0] <= side_i;
    end
  end

  // Restoring division, one quotient bit per stage.
  for (genvar i = 1; i <= DIV_BITS; i++) begin : g_bit
    logic [64:0] trial;
    logic [64:0] diff;
    logic        take;

    assign trial = {rem_q[i-1], quo_q[i-1][63]};
    assign diff  = trial - {1'b0, md_q[i-1]};
    assign take  = !diff[64];

    always_ff @(posedge clk_i) begin
      if (en_i[i]) begin
        rem_q[i]  <= take ? diff[63:0] : trial[63:0];
        quo_q[i]  <= {quo_q[i-1][62:0], take};
        md_q[i]   <= md_q[i-1];
        neg_q[i]  <= neg_q[i-1];
        inv_q[i]  <= inv_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // Sign of the quotient; truncation toward zero.
  always_ff @(posedge clk_i) begin
    if (en_i[DIV_ST-1]) begin
      fix_quo_q  <= neg_q[DIV_BITS] ? 64'd0 - quo_q[DIV_BITS] : quo_q[DIV_BITS];
      fix_inv_q  <= inv_q[DIV_BITS];
      fix_side_q <= side_q[DIV_BITS];
    end
  end

  assign quo_o  = fix_quo_q;
  assign inv_o  = fix_inv_q;
  assign side_o = fix_side_q;

endmodule

// ----- rtl/environmental_sensor_compensation_top.sv -----
// Pipeline: the 66-stage pressure divider (setup, one quotient bit per stage, sign) and
// 20 math stages.
// Throughput: one transaction per clock while m_axis_tready is high; each stage advances when
// its successor is free, so input is taken while a finished result waits if a later stage is empty.
// Reset: rst_ni (asynchronous, active low) clears all stage valid bits and all coefficient
// registers to zero; data registers are not reset.
`timescale 1ns / 1ps

module environmental_sensor_compensation_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream: tdata = temperature_raw[19:0], pressure_raw[39:20], humidity_raw[55:40].
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,
  // Master stream: tdata = temperature_centi[31:0], pressure_milli_pa[63:32],
  // humidity_q10[80:64], zeros[87:81].
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,
  // tuser = pressure_invalid[0].
  output logic        m_axis_tuser,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import esc_pkg::*;

  `include "environmental_sensor_compensation_top_assert.svh"

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [47:0] temp_coef_q, plow_coef_q, pmid_coef_q, phigh_coef_q;
  logic [31:0] huma_coef_q;
  logic [39:0] humb_coef_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes on the access phase of a write transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coef_q  <= '0;
      plow_coef_q  <= '0;
      pmid_coef_q  <= '0;
      phigh_coef_q <= '0;
      huma_coef_q  <= '0;
      humb_coef_q  <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_TEMP:  temp_coef_q  <= pwdata[47:0];
        REG_PLOW:  plow_coef_q  <= pwdata[47:0];
        REG_PMID:  pmid_coef_q  <= pwdata[47:0];
        REG_PHIGH: phigh_coef_q <= pwdata[47:0];
        REG_HUMA:  huma_coef_q  <= pwdata[31:0];
        REG_HUMB:  humb_coef_q  <= pwdata[39:0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    unique case (reg_idx)
      REG_TEMP:  prdata = {16'd0, temp_coef_q};
      REG_PLOW:  prdata = {16'd0, plow_coef_q};
      REG_PMID:  prdata = {16'd0, pmid_coef_q};
      REG_PHIGH: prdata = {16'd0, phigh_coef_q};
      REG_HUMA:  prdata = {32'd0, huma_coef_q};
      REG_HUMB:  prdata = {24'd0, humb_coef_q};
      default:   prdata = '0;
    endcase
  end

  // Coefficients widened to the working word of their path.
  logic [31:0] t1w, t2w, t3w, h1w, h2w, h3w, h4w, h5w, h6w;
  logic [63:0] p1x, p2x, p3x, p4x, p5x, p6x, p7x, p8x, p9x;

  assign t1w = {16'd0, temp_coef_q[15:0]};
  assign t2w = {{16{temp_coef_q[31]}}, temp_coef_q[31:16]};
  assign t3w = {{16{temp_coef_q[47]}}, temp_coef_q[47:32]};
  assign p1x = {48'd0, plow_coef_q[15:0]};
  assign p2x = {{48{plow_coef_q[31]}}, plow_coef_q[31:16]};
  assign p3x = {{48{plow_coef_q[47]}}, plow_coef_q[47:32]};
  assign p4x = {{48{pmid_coef_q[15]}}, pmid_coef_q[15:0]};
  assign p5x = {{48{pmid_coef_q[31]}}, pmid_coef_q[31:16]};
  assign p6x = {{48{pmid_coef_q[47]}}, pmid_coef_q[47:32]};
  assign p7x = {{48{phigh_coef_q[15]}}, phigh_coef_q[15:0]};
  assign p8x = {{48{phigh_coef_q[31]}}, phigh_coef_q[31:16]};
  assign p9x = {{48{phigh_coef_q[47]}}, phigh_coef_q[47:32]};
  assign h1w = {24'd0, huma_coef_q[7:0]};
  assign h2w = {{16{huma_coef_q[23]}}, huma_coef_q[23:8]};
  assign h3w = {24'd0, huma_coef_q[31:24]};
  assign h4w = {{16{humb_coef_q[15]}}, humb_coef_q[15:0]};
  assign h5w = {{16{humb_coef_q[31]}}, humb_coef_q[31:16]};
  assign h6w = {{24{humb_coef_q[39]}}, humb_coef_q[39:32]};

  // ---------------------------------------------------------------------------
  // Stage valid bits and per-stage advance enables
  // ---------------------------------------------------------------------------
  logic [NS-1:0] vld_q;
  logic [NS-1:0] en;

  // A stage loads when it is empty or when the stage after it loads.
  assign en[NS-1] = !vld_q[NS-1] || m_axis_tready;
  for (genvar k = 0; k < NS - 1; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) begin
        vld_q[0] <= s_axis_tvalid;
      end
      for (int unsigned k = 1; k < NS; k++) begin
        if (en[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NS-1];

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  logic [19:0] adc_t, adc_p;
  logic [15:0] adc_h;
  logic [31:0] temp_a, temp_b;

  assign adc_t  = s_axis_tdata[19:0];
  assign adc_p  = s_axis_tdata[39:20];
  assign adc_h  = s_axis_tdata[55:40];
  assign temp_a = {15'd0, adc_t[19:3]} - {t1w[30:0], 1'b0};
  assign temp_b = {16'd0, adc_t[19:4]} - t1w;

  logic [31:0] s0_m1_q, s0_bb_q, s1_m1_q, s1_m3_q, s2_tf_q;
  logic [19:0] s0_adcp_q, s1_adcp_q, s2_adcp_q, s3_adcp_q, s4_adcp_q;
  logic [19:0] s5_adcp_q, s6_adcp_q, s7_adcp_q, s8_adcp_q;
  logic [15:0] s0_adch_q, s1_adch_q, s2_adch_q, s3_adch_q, s4_adch_q;
  logic [31:0] s3_temp_q, s4_temp_q, s5_temp_q, s6_temp_q, s7_temp_q;
  logic [31:0] s8_temp_q, s9_temp_q, s10_temp_q, s11_temp_q;
  logic [63:0] s3_d_q;
  logic [31:0] s3_hv_q;
  pp_t         s4_pa_q, s4_pb_q, s4_pc_q;
  logic [31:0] s4_hm5_q, s4_hm6_q, s4_hm3_q;
  logic [63:0] s5_dd_q, s5_dp5_q, s5_dp2_q;
  logic [31:0] s5_f1_q, s5_f2a_q, s5_f2b_q;
  pp_t         s6_pd_q, s6_pe_q;
  logic [63:0] s6_dp5_q, s6_dp2_q;
  logic [31:0] s6_hm_q, s6_f1_q;
  logic [63:0] s7_y2s_q, s7_de3_q, s7_dp2_q;
  logic [31:0] s7_f2c_q, s7_f1_q;
  logic [63:0] s8_y2_q, s8_y1a_q;
  logic [31:0] s8_hm_q, s8_f1_q;
  logic [63:0] s9_w_q, s9_n0_q;
  logic [31:0] s9_f2_q, s9_f1_q;
  pp_t         s10_pf_q, s10_pg_q;
  logic [31:0] s10_v2_q;
  logic [63:0] s11_den_q, s11_num_q;
  logic [31:0] s11_v2_q, s11_sq_q;

  // Front section: temperature, pressure divisor and dividend, humidity terms.
  always_ff @(posedge clk_i) begin
    // Temperature products.
    if (en[0]) begin
      s0_m1_q   <= temp_a * t2w;
      s0_bb_q   <= temp_b * temp_b;
      s0_adcp_q <= adc_p;
      s0_adch_q <= adc_h;
    end
    if (en[1]) begin
      s1_m1_q   <= s0_m1_q;
      s1_m3_q   <= asr32(s0_bb_q, 12) * t3w;
      s1_adcp_q <= s0_adcp_q;
      s1_adch_q <= s0_adch_q;
    end
    // Fine temperature.
    if (en[2]) begin
      s2_tf_q   <= asr32(s1_m1_q, 11) + asr32(s1_m3_q, 14);
      s2_adcp_q <= s1_adcp_q;
      s2_adch_q <= s1_adch_q;
    end
    // Temperature result and the offsets for the other two paths.
    if (en[3]) begin
      s3_temp_q <= asr32(s2_tf_q + {s2_tf_q[29:0], 2'b00} + T_ROUND, 8);
      s3_d_q    <= {{32{s2_tf_q[31]}}, s2_tf_q} - T_FINE_P_OFS;
      s3_hv_q   <= s2_tf_q - T_FINE_H_OFS;
      s3_adcp_q <= s2_adcp_q;
      s3_adch_q <= s2_adch_q;
    end
    // Partial products of d*d, d*P5, d*P2 and humidity products.
    if (en[4]) begin
      s4_pa_q   <= pp_mul(s3_d_q, s3_d_q);
      s4_pb_q   <= pp_mul(s3_d_q, p5x);
      s4_pc_q   <= pp_mul(s3_d_q, p2x);
      s4_hm5_q  <= s3_hv_q * h5w;
      s4_hm6_q  <= s3_hv_q * h6w;
      s4_hm3_q  <= s3_hv_q * h3w;
      s4_temp_q <= s3_temp_q;
      s4_adcp_q <= s3_adcp_q;
      s4_adch_q <= s3_adch_q;
    end
    if (en[5]) begin
      s5_dd_q   <= pp_sum(s4_pa_q);
      s5_dp5_q  <= pp_sum(s4_pb_q);
      s5_dp2_q  <= pp_sum(s4_pc_q);
      s5_f1_q   <= asr32({2'b00, s4_adch_q, 14'd0} - {h4w[11:0], 20'd0} - s4_hm5_q
                         + H_ROUND_F1, 15);
      s5_f2a_q  <= asr32(s4_hm6_q, 10);
      s5_f2b_q  <= asr32(s4_hm3_q, 11) + H_OFS_F2B;
      s5_temp_q <= s4_temp_q;
      s5_adcp_q <= s4_adcp_q;
    end
    if (en[6]) begin
      s6_pd_q   <= pp_mul(s5_dd_q, p6x);
      s6_pe_q   <= pp_mul(s5_dd_q, p3x);
      s6_dp5_q  <= s5_dp5_q;
      s6_dp2_q  <= s5_dp2_q;
      s6_hm_q   <= s5_f2a_q * s5_f2b_q;
      s6_f1_q   <= s5_f1_q;
      s6_temp_q <= s5_temp_q;
      s6_adcp_q <= s5_adcp_q;
    end
    if (en[7]) begin
      s7_y2s_q  <= pp_sum(s6_pd_q) + {s6_dp5_q[46:0], 17'd0};
      s7_de3_q  <= pp_sum(s6_pe_q);
      s7_dp2_q  <= s6_dp2_q;
      s7_f2c_q  <= asr32(s6_hm_q, 10) + H_OFS_F2C;
      s7_f1_q   <= s6_f1_q;
      s7_temp_q <= s6_temp_q;
      s7_adcp_q <= s6_adcp_q;
    end
    if (en[8]) begin
      s8_y2_q   <= s7_y2s_q + {p4x[28:0], 35'd0};
      s8_y1a_q  <= asr64(s7_de3_q, 8) + {s7_dp2_q[51:0], 12'd0};
      s8_hm_q   <= s7_f2c_q * h2w;
      s8_f1_q   <= s7_f1_q;
      s8_temp_q <= s7_temp_q;
      s8_adcp_q <= s7_adcp_q;
    end
    // Divisor bias and dividend before scaling.
    if (en[9]) begin
      s9_w_q    <= s8_y1a_q + P_BIAS47;
      s9_n0_q   <= ((P_RAW_FULL - {44'd0, s8_adcp_q}) << 31) - s8_y2_q;
      s9_f2_q   <= asr32(s8_hm_q + H_ROUND_F2, 14);
      s9_f1_q   <= s8_f1_q;
      s9_temp_q <= s8_temp_q;
    end
    if (en[10]) begin
      s10_pf_q   <= pp_mul(s9_w_q, p1x);
      s10_pg_q   <= pp_mul(s9_n0_q, P_SCALE);
      s10_v2_q   <= s9_f1_q * s9_f2_q;
      s10_temp_q <= s9_temp_q;
    end
    if (en[11]) begin
      s11_den_q  <= asr64(pp_sum(s10_pf_q), 33);
      s11_num_q  <= pp_sum(s10_pg_q);
      s11_v2_q   <= s10_v2_q;
      s11_sq_q   <= asr32(s10_v2_q, 15) * asr32(s10_v2_q, 15);
      s11_temp_q <= s10_temp_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Pressure divider
  // ---------------------------------------------------------------------------
  side_t       div_side_in, div_side_out;
  logic [63:0] div_quo;
  logic        div_inv;

  assign div_side_in = '{temp: s11_temp_q, v2: s11_v2_q, sq: s11_sq_q};

  esc_sdiv u_sdiv (
    .clk_i  (clk_i),
    .en_i   (en[DIV_HI:DIV_LO]),
    .num_i  (s11_num_q),
    .den_i  (s11_den_q),
    .side_i (div_side_in),
    .quo_o  (div_quo),
    .inv_o  (div_inv),
    .side_o (div_side_out)
  );

  // ---------------------------------------------------------------------------
  // Back section: pressure correction, humidity finish, output register
  // ---------------------------------------------------------------------------
  logic [63:0] s78_p_q, s79_p_q, s80_p_q, s81_p_q;
  pp_t         s78_ph_q, s78_pi_q, s80_pj_q;
  logic        s78_inv_q, s79_inv_q, s80_inv_q, s81_inv_q, s82_inv_q, s83_inv_q, s84_inv_q;
  logic [31:0] s78_temp_q, s79_temp_q, s80_temp_q, s81_temp_q, s82_temp_q, s83_temp_q;
  logic [31:0] s84_temp_q;
  logic [31:0] s78_hm_q, s78_v2_q;
  logic [63:0] s79_qsq_q, s79_y2b_q, s80_y2b_q, s81_y2b_q, s81_y1b_q;
  logic [16:0] s79_hum_q, s80_hum_q, s81_hum_q, s82_hum_q, s83_hum_q, s84_hum_q;
  logic [63:0] s82_s_q, s83_pf_q;
  logic [31:0] s84_hi_q, s84_lo_q;
  logic [87:0] out_data_q;
  logic        out_inv_q;
  logic [63:0] quo_sh;
  logic [31:0] hum_v3, hum_clamp;
  logic [14:0] frac_prod;

  assign quo_sh    = asr64(div_quo, 13);
  assign hum_v3    = s78_v2_q - asr32(s78_hm_q, 4);
  assign hum_clamp = hum_v3[31] ? 32'd0 : ((hum_v3 > HUM_MAX) ? HUM_MAX : hum_v3);
  assign frac_prod = s83_pf_q[7:0] * FRAC_MUL;

  always_ff @(posedge clk_i) begin
    if (en[78]) begin
      s78_ph_q   <= pp_mul(quo_sh, quo_sh);
      s78_pi_q   <= pp_mul(p8x, div_quo);
      s78_p_q    <= div_quo;
      s78_inv_q  <= div_inv;
      s78_temp_q <= div_side_out.temp;
      s78_hm_q   <= asr32(div_side_out.sq, 7) * h1w;
      s78_v2_q   <= div_side_out.v2;
    end
    if (en[79]) begin
      s79_qsq_q  <= pp_sum(s78_ph_q);
      s79_y2b_q  <= asr64(pp_sum(s78_pi_q), 19);
      s79_p_q    <= s78_p_q;
      s79_inv_q  <= s78_inv_q;
      s79_temp_q <= s78_temp_q;
      s79_hum_q  <= hum_clamp[28:12];
    end
    if (en[80]) begin
      s80_pj_q   <= pp_mul(p9x, s79_qsq_q);
      s80_y2b_q  <= s79_y2b_q;
      s80_p_q    <= s79_p_q;
      s80_inv_q  <= s79_inv_q;
      s80_temp_q <= s79_temp_q;
      s80_hum_q  <= s79_hum_q;
    end
    if (en[81]) begin
      s81_y1b_q  <= asr64(pp_sum(s80_pj_q), 25);
      s81_y2b_q  <= s80_y2b_q;
      s81_p_q    <= s80_p_q;
      s81_inv_q  <= s80_inv_q;
      s81_temp_q <= s80_temp_q;
      s81_hum_q  <= s80_hum_q;
    end
    if (en[82]) begin
      s82_s_q    <= s81_p_q + s81_y1b_q + s81_y2b_q;
      s82_inv_q  <= s81_inv_q;
      s82_temp_q <= s81_temp_q;
      s82_hum_q  <= s81_hum_q;
    end
    // Pressure in Q56.8 pascal.
    if (en[83]) begin
      s83_pf_q   <= asr64(s82_s_q, 8) + {p7x[59:0], 4'd0};
      s83_inv_q  <= s82_inv_q;
      s83_temp_q <= s82_temp_q;
      s83_hum_q  <= s82_hum_q;
    end
    // Whole pascal times 1000 plus the scaled fraction.
    if (en[84]) begin
      s84_hi_q   <= s83_pf_q[39:8] * MPA_PER_PA;
      s84_lo_q   <= {22'd0, frac_prod[14:5]};
      s84_inv_q  <= s83_inv_q;
      s84_temp_q <= s83_temp_q;
      s84_hum_q  <= s83_hum_q;
    end
    // Output register; a zero divisor forces the pressure to zero.
    if (en[85]) begin
      out_data_q <= {7'd0, s84_hum_q, s84_inv_q ? 32'd0 : s84_hi_q + s84_lo_q, s84_temp_q};
      out_inv_q  <= s84_inv_q;
    end
  end

  assign m_axis_tdata = out_data_q;
  assign m_axis_tuser = out_inv_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `ESC_ASSERT_NOW(a_stall_only_when_full, !s_axis_tready, (&vld_q) && !m_axis_tready,
                  "input stalled although a pipeline stage is free")
  `ESC_ASSERT_NEXT(a_accept_fills_stage0, s_axis_tvalid && s_axis_tready, vld_q[0],
                   "accepted transaction did not enter the first stage")
  `ESC_ASSERT_NOW(a_invalid_zero_pressure, m_axis_tvalid && m_axis_tuser,
                  m_axis_tdata[63:32] == 32'd0,
                  "pressure not forced to zero on a zero divisor")
  `ESC_ASSERT_NOW(a_humidity_range, m_axis_tvalid, m_axis_tdata[80:64] <= 17'd102400,
                  "humidity above the clamp limit")

endmodule
